>>> rtl/core/rsn_akm_suite_parser_assert.svh
// assertion macros for the rsn akm suite parser
// no dependencies; taken in by the files that carry assertions
`ifndef RSN_AKM_SUITE_PARSER_ASSERT_SVH
`define RSN_AKM_SUITE_PARSER_ASSERT_SVH

// implication in the same cycle
`define RSNAKM_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsnakm assertion failed");

// implication in the next cycle
`define RSNAKM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsnakm assertion failed");

`endif

>>> rtl/core/rsnakm_pkg.sv
// types, constants and state layout of the rsn akm suite parser
// no dependencies; used by the parse step and the top level
`default_nettype none

package rsnakm_pkg;

   localparam int MaxElementBytes = 257;
   localparam int PosWidth        = $clog2(MaxElementBytes + 1);
   localparam int LeftWidth       = 18;

   localparam logic [PosWidth-1:0]  RsnHeaderLen = PosWidth'(2);
   localparam logic [PosWidth-1:0]  WpaHeaderLen = PosWidth'(6);
   localparam logic [PosWidth-1:0]  PosLimit     = PosWidth'(MaxElementBytes);
   localparam logic [LeftWidth-1:0] FixedLen     = LeftWidth'(6);
   localparam logic [LeftWidth-1:0] CountLen     = LeftWidth'(2);
   localparam logic [LeftWidth-1:0] CountHighLen = LeftWidth'(1);

   localparam logic KindRsn = 1'b0;
   localparam logic KindWpa = 1'b1;

   localparam logic [7:0] OuiByte0    = 8'h00;
   localparam logic [7:0] WpaOuiByte1 = 8'h50;
   localparam logic [7:0] WpaOuiByte2 = 8'hf2;
   localparam logic [7:0] RsnOuiByte1 = 8'h0f;
   localparam logic [7:0] RsnOuiByte2 = 8'hac;

   localparam logic [7:0] AkmType8021x = 8'h01;
   localparam logic [7:0] AkmTypePsk   = 8'h02;

   // oui match bits: bit 0 wpa oui, bit 1 rsn oui
   localparam logic [1:0] OuiBoth    = 2'b11;
   localparam logic [1:0] OuiKeepWpa = 2'b01;
   localparam logic [1:0] OuiKeepRsn = 2'b10;

   localparam int FlagIeee8021x = 0;
   localparam int FlagPsk       = 1;

   localparam logic [1:0] SuiteOui0 = 2'd0;
   localparam logic [1:0] SuiteOui1 = 2'd1;
   localparam logic [1:0] SuiteOui2 = 2'd2;

   typedef enum logic [1:0] {
      ClassNone      = 2'd0,
      ClassWep       = 2'd1,
      ClassPsk       = 2'd2,
      ClassIeee8021x = 2'd3
   } security_class_type;

   typedef enum logic [6:0] {
      PhHeader = 7'b0000001,
      PhFixed  = 7'b0000010,
      PhPcount = 7'b0000100,
      PhPlist  = 7'b0001000,
      PhAcount = 7'b0010000,
      PhAlist  = 7'b0100000,
      PhDone   = 7'b1000000
   } parse_phase_type;

   typedef struct packed {
      parse_phase_type      phase;
      logic [PosWidth-1:0]  byte_position;
      logic [LeftWidth-1:0] bytes_left;
      logic [7:0]           count_low;
      logic [1:0]           suite_index;
      logic [1:0]           oui_match;
      logic [1:0]           flags;
      logic                 list_complete;
   } parse_state_type;

   localparam parse_state_type StateReset = '{
      phase:         PhHeader,
      byte_position: '0,
      bytes_left:    '0,
      count_low:     '0,
      suite_index:   '0,
      oui_match:     OuiBoth,
      flags:         '0,
      list_complete: 1'b0
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
      logic       element_kind;
      logic       privacy_bit;
   } req_beat_type;

   typedef struct packed {
      logic               akm_ieee8021x;
      logic               akm_psk;
      logic               parsed_ok;
      security_class_type security_class;
   } rsp_beat_type;

endpackage

`default_nettype wire

>>> rtl/core/rsnakm_req_if.sv
// input channel of the rsn akm suite parser: one element byte per beat
// no dependencies
`default_nettype none

interface rsnakm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       last_byte;
   logic       element_kind;
   logic       privacy_bit;

   modport source (
      output valid, data_byte, first_byte, last_byte, element_kind, privacy_bit,
      input  ready
   );
   modport sink (
      input  valid, data_byte, first_byte, last_byte, element_kind, privacy_bit,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/rsnakm_rsp_if.sv
// result channel of the rsn akm suite parser: one result per element
// no dependencies
`default_nettype none

interface rsnakm_rsp_if;
   logic       valid;
   logic       ready;
   logic       akm_ieee8021x;
   logic       akm_psk;
   logic       parsed_ok;
   logic [1:0] security_class;

   modport source (
      output valid, akm_ieee8021x, akm_psk, parsed_ok, security_class,
      input  ready
   );
   modport sink (
      input  valid, akm_ieee8021x, akm_psk, parsed_ok, security_class,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/rsnakm_parse.sv
// per-byte state update and result of the rsn akm suite parser
// depends on rsnakm_pkg
`default_nettype none

module rsnakm_parse (
   input  rsnakm_pkg::parse_state_type state_cur,
   input  rsnakm_pkg::req_beat_type    beat,
   output rsnakm_pkg::parse_state_type state_nxt,
   output rsnakm_pkg::rsp_beat_type    result
);
   import rsnakm_pkg::*;

   parse_state_type      s;
   logic [PosWidth-1:0]  hdr_len;
   logic [PosWidth:0]    pos_inc;
   logic [LeftWidth-1:0] left_dec;
   logic [LeftWidth-1:0] count_word;
   logic [7:0]           b;
   logic                 x_flag;
   logic                 p_flag;

   always_comb begin
      s          = beat.first_byte ? StateReset : state_cur;
      b          = beat.data_byte;
      hdr_len    = (beat.element_kind == KindWpa) ? WpaHeaderLen : RsnHeaderLen;
      pos_inc    = {1'b0, s.byte_position} + (PosWidth + 1)'(1);
      left_dec   = s.bytes_left - LeftWidth'(1);
      count_word = {b, s.count_low, 2'b00};

      if (s.byte_position < PosLimit) begin
         case (s.phase)
            PhHeader: begin
               if (pos_inc >= {1'b0, hdr_len}) begin
                  s.phase      = PhFixed;
                  s.bytes_left = FixedLen;
               end
            end
            PhFixed: begin
               s.bytes_left = left_dec;
               if (left_dec == '0) begin
                  s.phase      = PhPcount;
                  s.bytes_left = CountLen;
               end
            end
            PhPcount, PhAcount: begin
               if (s.bytes_left == CountLen) begin
                  s.count_low  = b;
                  s.bytes_left = CountHighLen;
               end else begin
                  s.bytes_left = count_word;
                  if (s.phase == PhPcount) begin
                     if (count_word == '0) begin
                        s.phase      = PhAcount;
                        s.bytes_left = CountLen;
                     end else begin
                        s.phase = PhPlist;
                     end
                  end else begin
                     s.suite_index = '0;
                     s.oui_match   = OuiBoth;
                     if (count_word == '0) begin
                        s.list_complete = 1'b1;
                        s.phase         = PhDone;
                     end else begin
                        s.phase = PhAlist;
                     end
                  end
               end
            end
            PhPlist: begin
               s.bytes_left = left_dec;
               if (left_dec == '0) begin
                  s.phase      = PhAcount;
                  s.bytes_left = CountLen;
               end
            end
            PhAlist: begin
               case (s.suite_index)
                  SuiteOui0: begin
                     if (b != OuiByte0) s.oui_match = '0;
                  end
                  SuiteOui1: begin
                     if (b != WpaOuiByte1) s.oui_match = s.oui_match & OuiKeepRsn;
                     if (b != RsnOuiByte1) s.oui_match = s.oui_match & OuiKeepWpa;
                  end
                  SuiteOui2: begin
                     if (b != WpaOuiByte2) s.oui_match = s.oui_match & OuiKeepRsn;
                     if (b != RsnOuiByte2) s.oui_match = s.oui_match & OuiKeepWpa;
                  end
                  default: begin
                     // suite type byte
                     if (s.oui_match != '0) begin
                        if (b == AkmType8021x) begin
                           s.flags[FlagIeee8021x] = 1'b1;
                        end else if (b == AkmTypePsk) begin
                           s.flags[FlagPsk] = 1'b1;
                        end
                     end
                     s.oui_match = OuiBoth;
                  end
               endcase
               s.suite_index = s.suite_index + 2'd1;
               s.bytes_left  = left_dec;
               if (left_dec == '0) begin
                  s.list_complete = 1'b1;
                  s.phase         = PhDone;
               end
            end
            default: begin
            end
         endcase
         s.byte_position = pos_inc[PosWidth-1:0];
      end

      x_flag = s.list_complete & s.flags[FlagIeee8021x];
      p_flag = s.list_complete & s.flags[FlagPsk];

      result.akm_ieee8021x = x_flag;
      result.akm_psk       = p_flag;
      result.parsed_ok     = s.list_complete;
      if (x_flag) begin
         result.security_class = ClassIeee8021x;
      end else if (p_flag) begin
         result.security_class = ClassPsk;
      end else if (beat.privacy_bit) begin
         result.security_class = ClassWep;
      end else begin
         result.security_class = ClassNone;
      end

      state_nxt = beat.last_byte ? StateReset : s;
   end

endmodule

`default_nettype wire

>>> rtl/core/rsn_akm_suite_parser.sv
// top level of the rsn akm suite parser: input register, parse step, result register
// depends on rsnakm_pkg, rsnakm_req_if, rsnakm_rsp_if, rsnakm_parse
//
// req_bus carries the bytes of one rsn or wpa information element, tag byte
// first, one byte per beat, with first_byte on the tag byte and last_byte on
// the final byte. element_kind selects the header length, privacy_bit is
// sampled on the final byte.
// rsp_bus carries one result beat per element, produced by its last byte:
// akm flags, parsed_ok and the security class. other bytes give no beat.
// throughput: one byte per cycle while rsp_bus does not stall, through the
// combinational parse step between the input register and the result register.
// a result is registered when its last byte advances out of the input register.
// reset clears both valid bits and returns the parser to the tag byte state.
// when rsp_bus stalls, the result register holds its beat, at most one more byte is
// taken into the input register, and req_bus.ready then drops until the
// result beat is taken.
`default_nettype none
`include "rsn_akm_suite_parser_assert.svh"

module rsn_akm_suite_parser (
   input  logic       clock,
   input  logic       reset,
   rsnakm_req_if.sink   req_bus,
   rsnakm_rsp_if.source rsp_bus
);
   import rsnakm_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   req_beat_type    in_beat_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   rsp_beat_type    result;
   rsp_beat_type    out_beat_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   logic            out_free;
   logic            advance;
   logic            req_fire;

   rsnakm_parse u_parse (
      .state_cur (state_ff),
      .beat      (in_beat_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign advance       = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = in_beat_ff.last_byte;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= StateReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_beat_ff <= '{
            data_byte:    req_bus.data_byte,
            first_byte:   req_bus.first_byte,
            last_byte:    req_bus.last_byte,
            element_kind: req_bus.element_kind,
            privacy_bit:  req_bus.privacy_bit
         };
      end
      if (advance && in_beat_ff.last_byte) out_beat_ff <= result;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.akm_ieee8021x  = out_beat_ff.akm_ieee8021x;
   assign rsp_bus.akm_psk        = out_beat_ff.akm_psk;
   assign rsp_bus.parsed_ok      = out_beat_ff.parsed_ok;
   assign rsp_bus.security_class = out_beat_ff.security_class;

   `RSNAKM_ASSERT_NEXT(in_held_on_stall, clock, reset, in_valid_ff && !out_free, in_valid_ff)
   `RSNAKM_ASSERT_NEXT(last_gives_result, clock, reset, advance && in_beat_ff.last_byte, out_valid_ff)
   `RSNAKM_ASSERT_NEXT(last_clears_state, clock, reset, advance && in_beat_ff.last_byte, state_ff == StateReset)
   `RSNAKM_ASSERT_IMPL(position_bounded, clock, reset, 1'b1, state_ff.byte_position <= PosLimit)

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// testbench for rsn_akm_suite_parser: a short table of element bytes, then random elements
// checked beat by beat against a local scan of the akm suite list
// depends on rsnakm_pkg, rsnakm_req_if, rsnakm_rsp_if and the parser rtl

module tb_top;
   import rsnakm_pkg::*;

   localparam int ItemTarget = 1000;
   localparam int StallLimit = 3000;
   localparam int HoldCycles = 150;
   localparam int MaxReports = 10;
   localparam int TailCycles = 8;
   localparam logic [1:0] OuiNone = 2'b00;

   typedef struct packed {
      req_beat_type beat;
      logic         typed;
      rsp_beat_type rsp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic idle_on = 1'b1;
   logic hold_request = 1'b0;

   rsnakm_req_if req_bus ();
   rsnakm_rsp_if rsp_bus ();

   rsn_akm_suite_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // local copy of the element scan
   parse_phase_type      scan_phase;
   logic [PosWidth-1:0]  scan_pos;
   logic [LeftWidth-1:0] scan_left;
   logic [7:0]           scan_count_low;
   logic [1:0]           scan_index;
   logic [1:0]           scan_oui;
   logic [1:0]           scan_flags;
   logic                 scan_complete;

   rsp_beat_type akm_result_q[$];
   req_beat_type elem_q[$];
   stim_row_type stim_rows[$];
   logic         elem_kind;
   rsp_beat_type checked_rsp;

   int failures = 0;
   int items_sent = 0;
   int elements_sent = 0;
   int results_checked = 0;
   int complete_lists = 0;
   int ieee8021x_seen = 0;
   int psk_seen = 0;

   task automatic clear_scan();
      scan_phase     = PhHeader;
      scan_pos       = '0;
      scan_left      = '0;
      scan_count_low = '0;
      scan_index     = SuiteOui0;
      scan_oui       = OuiBoth;
      scan_flags     = '0;
      scan_complete  = 1'b0;
   endtask

   task automatic scan_suite_byte(input logic [7:0] d);
      case (scan_index)
         SuiteOui0: begin
            if (d != OuiByte0) scan_oui = OuiNone;
         end
         SuiteOui1: begin
            if (d != WpaOuiByte1) scan_oui = scan_oui & OuiKeepRsn;
            if (d != RsnOuiByte1) scan_oui = scan_oui & OuiKeepWpa;
         end
         SuiteOui2: begin
            if (d != WpaOuiByte2) scan_oui = scan_oui & OuiKeepRsn;
            if (d != RsnOuiByte2) scan_oui = scan_oui & OuiKeepWpa;
         end
         default: begin
            if (scan_oui != OuiNone) begin
               if (d == AkmType8021x) scan_flags[FlagIeee8021x] = 1'b1;
               else if (d == AkmTypePsk) scan_flags[FlagPsk] = 1'b1;
            end
            scan_oui = OuiBoth;
         end
      endcase
      scan_index = scan_index + 2'd1;
   endtask

   task automatic consume_element_byte(input logic [7:0] d, input logic kind);
      logic [PosWidth-1:0] hdr_len;
      logic [15:0]         count;
      hdr_len = (kind == KindWpa) ? WpaHeaderLen : RsnHeaderLen;
      case (scan_phase)
         PhHeader: begin
            if (scan_pos + PosWidth'(1) >= hdr_len) begin
               scan_phase = PhFixed;
               scan_left  = FixedLen;
            end
         end
         PhFixed: begin
            scan_left = scan_left - LeftWidth'(1);
            if (scan_left == '0) begin
               scan_phase = PhPcount;
               scan_left  = CountLen;
            end
         end
         PhPcount, PhAcount: begin
            if (scan_left == CountLen) begin
               scan_count_low = d;
               scan_left      = CountHighLen;
            end else begin
               count     = {d, scan_count_low};
               scan_left = {count, 2'b00};
               if (scan_phase == PhPcount) begin
                  if (scan_left == '0) begin
                     scan_phase = PhAcount;
                     scan_left  = CountLen;
                  end else begin
                     scan_phase = PhPlist;
                  end
               end else begin
                  scan_index = SuiteOui0;
                  scan_oui   = OuiBoth;
                  if (scan_left == '0) begin
                     scan_complete = 1'b1;
                     scan_phase    = PhDone;
                  end else begin
                     scan_phase = PhAlist;
                  end
               end
            end
         end
         PhPlist: begin
            scan_left = scan_left - LeftWidth'(1);
            if (scan_left == '0) begin
               scan_phase = PhAcount;
               scan_left  = CountLen;
            end
         end
         PhAlist: begin
            scan_suite_byte(d);
            scan_left = scan_left - LeftWidth'(1);
            if (scan_left == '0) begin
               scan_complete = 1'b1;
               scan_phase    = PhDone;
            end
         end
         default: ;
      endcase
   endtask

   task automatic predict_akm_result(input req_beat_type b, output logic has_rsp,
                                     output rsp_beat_type res);
      logic x;
      logic p;
      if (b.first_byte) clear_scan();
      if (scan_pos < PosLimit) begin
         consume_element_byte(b.data_byte, b.element_kind);
         scan_pos = scan_pos + PosWidth'(1);
      end
      has_rsp = b.last_byte;
      res = '0;
      if (b.last_byte) begin
         x = scan_complete & scan_flags[FlagIeee8021x];
         p = scan_complete & scan_flags[FlagPsk];
         res.akm_ieee8021x = x;
         res.akm_psk       = p;
         res.parsed_ok     = scan_complete;
         if (x) res.security_class = ClassIeee8021x;
         else if (p) res.security_class = ClassPsk;
         else if (b.privacy_bit) res.security_class = ClassWep;
         else res.security_class = ClassNone;
         clear_scan();
      end
   endtask

   task automatic log_failure(input string what);
      if (failures < MaxReports) $display("%s", what);
      failures++;
   endtask

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic offer_beat(input req_beat_type b, input logic typed, input rsp_beat_type typed_rsp);
      logic         has_rsp;
      rsp_beat_type res;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.data_byte    = b.data_byte;
      req_bus.first_byte   = b.first_byte;
      req_bus.last_byte    = b.last_byte;
      req_bus.element_kind = b.element_kind;
      req_bus.privacy_bit  = b.privacy_bit;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_akm_result(b, has_rsp, res);
      if (has_rsp) begin
         if (typed) res = typed_rsp;
         akm_result_q.push_back(res);
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic add_byte(input logic [7:0] d, input logic first, input logic kind);
      stim_row_type row;
      req_beat_type b;
      b.data_byte    = d;
      b.first_byte   = first;
      b.last_byte    = 1'b0;
      b.element_kind = kind;
      b.privacy_bit  = 1'b0;
      row.beat  = b;
      row.typed = 1'b0;
      row.rsp   = '0;
      stim_rows.push_back(row);
   endtask

   task automatic add_last(input logic [7:0] d, input logic first, input logic kind,
                           input logic privacy, input logic x, input logic p, input logic ok,
                           input security_class_type cls);
      stim_row_type row;
      req_beat_type b;
      rsp_beat_type r;
      b.data_byte        = d;
      b.first_byte       = first;
      b.last_byte        = 1'b1;
      b.element_kind     = kind;
      b.privacy_bit      = privacy;
      r.akm_ieee8021x    = x;
      r.akm_psk          = p;
      r.parsed_ok        = ok;
      r.security_class   = cls;
      row.beat  = b;
      row.typed = 1'b1;
      row.rsp   = r;
      stim_rows.push_back(row);
   endtask

   task automatic push_data(input logic [7:0] d);
      req_beat_type b;
      b.data_byte    = d;
      b.first_byte   = 1'b0;
      b.last_byte    = 1'b0;
      b.element_kind = ($urandom_range(0, 24) == 0) ? ~elem_kind : elem_kind;
      b.privacy_bit  = 1'($urandom_range(0, 1));
      elem_q.push_back(b);
   endtask

   task automatic push_suite(input int oui_sel, input int type_sel);
      case (oui_sel)
         0, 1: begin
            push_data(OuiByte0); push_data(WpaOuiByte1); push_data(WpaOuiByte2);
         end
         2, 3: begin
            push_data(OuiByte0); push_data(RsnOuiByte1); push_data(RsnOuiByte2);
         end
         4: begin
            // one byte off a known oui
            case ($urandom_range(0, 2))
               0: begin push_data(OuiByte0); push_data(WpaOuiByte1); push_data(RsnOuiByte2); end
               1: begin push_data(OuiByte0); push_data(RsnOuiByte1); push_data(WpaOuiByte2); end
               default: begin
                  push_data(8'($urandom_range(1, 255))); push_data(WpaOuiByte1);
                  push_data(WpaOuiByte2);
               end
            endcase
         end
         default: begin
            push_data(8'($urandom)); push_data(8'($urandom)); push_data(8'($urandom));
         end
      endcase
      case (type_sel)
         0, 1:    push_data(AkmType8021x);
         2, 3:    push_data(AkmTypePsk);
         default: push_data(8'($urandom));
      endcase
   endtask

   task automatic make_element(input int pcnt, input int acnt, input logic huge_count,
                               input int tail);
      logic [15:0]  pcount;
      logic [15:0]  acount;
      req_beat_type b;
      int           k;
      elem_q.delete();
      elem_kind = 1'($urandom_range(0, 1));
      if (elem_kind == KindWpa) begin
         push_data(8'hdd); push_data(8'h00);
         push_data(OuiByte0); push_data(WpaOuiByte1); push_data(WpaOuiByte2); push_data(8'h01);
      end else begin
         push_data(8'h30); push_data(8'h00);
      end
      if ($urandom_range(0, 3) == 0) begin
         push_data(8'($urandom)); push_data(8'($urandom));
      end else begin
         push_data(8'h01); push_data(8'h00);
      end
      push_suite($urandom_range(0, 5), 4);
      pcount = 16'(pcnt);
      push_data(pcount[7:0]); push_data(pcount[15:8]);
      for (k = 0; k < pcnt; k++) push_suite($urandom_range(0, 5), $urandom_range(0, 4));
      acount = 16'(acnt);
      if (huge_count) acount[15:8] = 8'($urandom_range(1, 255));
      push_data(acount[7:0]); push_data(acount[15:8]);
      for (k = 0; k < acnt; k++) push_suite($urandom_range(0, 5), $urandom_range(0, 4));
      repeat (tail) push_data(8'($urandom));
      b = elem_q[1];
      b.data_byte = 8'(elem_q.size() - 2);
      elem_q[1] = b;
   endtask

   task automatic mark_element(input logic mark_first);
      req_beat_type b;
      b = elem_q[0];
      b.first_byte = mark_first;
      elem_q[0] = b;
      b = elem_q[elem_q.size() - 1];
      b.last_byte = 1'b1;
      elem_q[elem_q.size() - 1] = b;
   endtask

   task automatic send_element();
      int k;
      for (k = 0; k < elem_q.size(); k++) offer_beat(elem_q[k], 1'b0, '0);
      elements_sent++;
   endtask

   task automatic wait_for_results();
      req_bus.valid = 1'b0;
      while (akm_result_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (akm_result_q.size() == 0) begin
            log_failure($sformatf("unexpected result beat: 8021x %0d psk %0d ok %0d class %0d",
               rsp_bus.akm_ieee8021x, rsp_bus.akm_psk, rsp_bus.parsed_ok,
               rsp_bus.security_class));
         end else begin
            checked_rsp = akm_result_q.pop_front();
            if (rsp_bus.akm_ieee8021x !== checked_rsp.akm_ieee8021x ||
                rsp_bus.akm_psk !== checked_rsp.akm_psk ||
                rsp_bus.parsed_ok !== checked_rsp.parsed_ok ||
                rsp_bus.security_class !== checked_rsp.security_class) begin
               log_failure($sformatf(
                  "result %0d mismatch: expected 8021x %0d psk %0d ok %0d class %0d, got %0d %0d %0d %0d",
                  results_checked, checked_rsp.akm_ieee8021x, checked_rsp.akm_psk,
                  checked_rsp.parsed_ok, checked_rsp.security_class, rsp_bus.akm_ieee8021x,
                  rsp_bus.akm_psk, rsp_bus.parsed_ok, rsp_bus.security_class));
            end
            results_checked++;
            if (checked_rsp.parsed_ok) complete_lists++;
            if (checked_rsp.akm_ieee8021x) ieee8021x_seen++;
            if (checked_rsp.akm_psk) psk_seen++;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < StallLimit) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("no beat accepted for %0d cycles", StallLimit);
      $display("simulation failed");
      $finish;
   end

   initial begin : rsp_side
      int   stall_left;
      logic hold_done;
      stall_left = 0;
      hold_done  = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_bus.ready = 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_done = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   initial begin : req_side
      int           i;
      int           k;
      int           pick;
      int           cut;
      int           random_start;
      int           overlong_done;
      logic         did_hold;
      logic         did_drain;
      req_beat_type b;
      stim_row_type row;
      req_bus.valid        = 1'b0;
      req_bus.data_byte    = '0;
      req_bus.first_byte   = 1'b0;
      req_bus.last_byte    = 1'b0;
      req_bus.element_kind = KindRsn;
      req_bus.privacy_bit  = 1'b0;
      clear_scan();
      overlong_done = 0;
      did_hold  = 1'b0;
      did_drain = 1'b0;

      // lone byte straight after reset, then one with no first mark
      add_last(8'hff, 1'b1, KindWpa, 1'b1, 1'b0, 1'b0, 1'b0, ClassWep);
      add_last(8'h00, 1'b0, KindRsn, 1'b0, 1'b0, 1'b0, 1'b0, ClassNone);
      // rsn element, 802.1x suite under the rsn oui and psk under the wpa oui
      add_byte(8'h30, 1'b1, KindRsn); add_byte(8'h12, 1'b0, KindRsn);
      add_byte(8'h01, 1'b0, KindRsn); add_byte(8'h00, 1'b0, KindRsn);
      add_byte(OuiByte0, 1'b0, KindRsn); add_byte(RsnOuiByte1, 1'b0, KindRsn);
      add_byte(RsnOuiByte2, 1'b0, KindRsn); add_byte(8'h04, 1'b0, KindRsn);
      add_byte(8'h00, 1'b0, KindRsn); add_byte(8'h00, 1'b0, KindRsn);
      add_byte(8'h02, 1'b0, KindRsn); add_byte(8'h00, 1'b0, KindRsn);
      add_byte(OuiByte0, 1'b0, KindRsn); add_byte(RsnOuiByte1, 1'b0, KindRsn);
      add_byte(RsnOuiByte2, 1'b0, KindRsn); add_byte(AkmType8021x, 1'b0, KindRsn);
      add_byte(OuiByte0, 1'b0, KindRsn); add_byte(WpaOuiByte1, 1'b0, KindRsn);
      add_byte(WpaOuiByte2, 1'b0, KindRsn);
      add_last(AkmTypePsk, 1'b0, KindRsn, 1'b0, 1'b1, 1'b1, 1'b1, ClassIeee8021x);
      // wpa element cut off by a new tag byte, the new element truncated
      add_byte(8'hdd, 1'b1, KindWpa); add_byte(8'h16, 1'b0, KindWpa);
      add_byte(8'h00, 1'b0, KindWpa);
      add_byte(8'h30, 1'b1, KindRsn); add_byte(8'hff, 1'b0, KindRsn);
      add_last(8'h01, 1'b0, KindRsn, 1'b0, 1'b0, 1'b0, 1'b0, ClassNone);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < stim_rows.size(); i++) begin
         row = stim_rows[i];
         offer_beat(row.beat, row.typed, row.rsp);
      end

      random_start = items_sent;
      while (items_sent - random_start < ItemTarget) begin
         if (!did_hold && items_sent - random_start > 300) begin
            hold_request = 1'b1;
            did_hold = 1'b1;
         end
         if (!did_drain && items_sent - random_start > 550) begin
            wait_for_results();
            did_drain = 1'b1;
         end
         if (items_sent - random_start > ItemTarget - 150) idle_on = 1'b0;
         else if ($urandom_range(0, 7) == 0) idle_on = ~idle_on;

         pick = $urandom_range(0, 99);
         if (overlong_done < 2 && items_sent - random_start > 150 + 400 * overlong_done) begin
            // pairwise list runs up to the position limit
            make_element($urandom_range(61, 62), $urandom_range(0, 1), 1'b0,
                         $urandom_range(4, 8));
            mark_element(1'b1);
            overlong_done++;
         end else if (pick < 65) begin
            make_element($urandom_range(0, 2), $urandom_range(0, 3),
                         $urandom_range(0, 11) == 0, $urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0) begin
               cut = $urandom_range(1, elem_q.size() - 1);
               while (elem_q.size() > cut) elem_q.delete(elem_q.size() - 1);
            end
            mark_element($urandom_range(0, 9) != 0);
         end else if (pick < 80) begin
            make_element($urandom_range(0, 2), $urandom_range(1, 3), 1'b0,
                         $urandom_range(0, 2));
            mark_element(1'b1);
            repeat ($urandom_range(1, 9)) begin
               b.data_byte    = 8'($urandom);
               b.first_byte   = 1'b0;
               b.last_byte    = 1'b0;
               b.element_kind = elem_kind;
               b.privacy_bit  = 1'($urandom_range(0, 1));
               elem_q.push_front(b);
            end
            b = elem_q[0];
            b.first_byte = 1'($urandom_range(0, 1));
            elem_q[0] = b;
         end else begin
            elem_q.delete();
            elem_kind = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 24)) push_data(8'($urandom));
            for (k = 1; k < elem_q.size(); k++) begin
               if ($urandom_range(0, 4) == 0) begin
                  b = elem_q[k];
                  b.first_byte = 1'b1;
                  elem_q[k] = b;
               end
            end
            mark_element(1'($urandom_range(0, 1)));
         end
         send_element();
      end

      wait_for_results();
      repeat (TailCycles) @(posedge clock);
      if (akm_result_q.size() != 0)
         log_failure($sformatf("%0d expected results never arrived", akm_result_q.size()));

      $display("sent %0d bytes in %0d random elements plus a directed table, %0d results checked",
         items_sent, elements_sent, results_checked);
      $display("%0d complete akm lists, %0d with 802.1x, %0d with psk, %0d failures",
         complete_lists, ieee8021x_seen, psk_seen, failures);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> rsn_akm_suite_parser.f
+incdir+rtl/core
rtl/core/rsnakm_pkg.sv
rtl/core/rsnakm_req_if.sv
rtl/core/rsnakm_rsp_if.sv
rtl/core/rsnakm_parse.sv
rtl/core/rsn_akm_suite_parser.sv
bench/tb_top.sv
